[rtl/acb_pkg.sv]
// Shared constants, codes and control types of the codebook ADPCM decoder.
package acb_pkg;

    localparam int PREDICTORS_DEF = 8;

    // Item kinds on the input channel.
    localparam logic [1:0] KIND_BOOK    = 2'd0;
    localparam logic [1:0] KIND_HISTORY = 2'd1;
    localparam logic [1:0] KIND_STREAM  = 2'd2;

    localparam int FRAC_BITS = 11;
    localparam int ACC_W     = 36;
    localparam int PROD_W    = 32;

    localparam logic signed [15:0] SAMPLE_MIN = -16'sh8000;
    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_INIT = 6'b000010,
        ST_RD   = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_ACC  = 6'b010000,
        ST_PUT  = 6'b100000
    } acb_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       take;
        logic       init;
        logic       mul;
        logic       acc;
        logic       put;
        logic       last;
        logic [2:0] j;
        logic [3:0] term;
    } acb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       decode;
        logic       two_bit;
        logic [2:0] base;
        logic       out_free;
    } acb_status_t;

endpackage

[rtl/acb_in_if.sv]
// Input channel of the decoder: one stream, codebook or history transaction.
interface acb_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [7:0]         stream_byte;
    logic [6:0]         book_index;
    logic signed [15:0] book_value;
    logic signed [15:0] history_newer;
    logic signed [15:0] history_older;

    modport source (output valid, kind, stream_byte, book_index, book_value,
                    history_newer, history_older, input ready);
    modport sink   (input valid, kind, stream_byte, book_index, book_value,
                    history_newer, history_older, output ready);
endinterface

[rtl/acb_out_if.sv]
// Output channel of the decoder: one decoded sample per transaction.
interface acb_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               last;

    modport source (output valid, sample, last, input ready);
    modport sink   (input valid, sample, last, output ready);
endinterface

[rtl/acb_cfg_if.sv]
// Configuration write channel carrying the residual mode register.
interface acb_cfg_if;
    logic valid;
    logic ready;
    logic two_bit_mode;

    modport source (output valid, two_bit_mode, input ready);
    modport sink   (input valid, two_bit_mode, output ready);
endinterface

[rtl/acb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module acb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/acb_datapath.sv]
// Datapath: frame state, residual group, codebook RAM, MAC and output register.
module acb_datapath #(
    parameter int PREDICTORS = acb_pkg::PREDICTORS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  two_bit_mode,
    input  logic [1:0]            kind,
    input  logic [7:0]            stream_byte,
    input  logic [6:0]            book_index,
    input  logic signed [15:0]    book_value,
    input  logic signed [15:0]    history_newer,
    input  logic signed [15:0]    history_older,
    input  acb_pkg::acb_cmd_t     cmd,
    output acb_pkg::acb_status_t  status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [15:0]    out_sample,
    output logic                  out_last
);
    import acb_pkg::*;

    localparam int BOOK_WORDS = PREDICTORS * 16;
    localparam int ADDR_W     = $clog2(BOOK_WORDS);

    logic [3:0]         pos_reg;
    logic [3:0]         shift_reg;
    logic [3:0]         pred_reg;
    logic signed [15:0] newer_reg;
    logic signed [15:0] older_reg;
    logic [15:0]        res_reg [8];
    logic [2:0]         base_reg;
    logic               two_reg;
    logic               endg_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [15:0] last_s_reg;
    logic               out_valid_reg;
    logic signed [15:0] out_sample_reg;
    logic               out_last_reg;

    logic [3:0]  pred_tab [16];
    logic        is_data;
    logic        book_we;
    logic [7:0]  waddr_w;
    logic [7:0]  raddr_w;
    logic [2:0]  col;
    logic        row;
    logic [15:0] coef;
    logic signed [15:0] operand;
    logic [3:0]  d;
    logic [1:0]  slot;
    logic [2:0]  base_new;
    logic        endg_new;
    logic [3:0]  flen;
    logic signed [ACC_W-FRAC_BITS-1:0] q;
    logic signed [15:0] q_sat;

    // Predictor index reduction, a constant table.
    for (genvar i = 0; i < 16; i++)
    begin : g_pred
        assign pred_tab[i] = 4'(i % PREDICTORS);
    end

    // Residual code to shifted, wrapped 16-bit value.
    function automatic logic [15:0] make_res(input logic [3:0] code, input logic two,
                                             input logic [3:0] sh);
        logic [15:0] v;
        begin
            if (two)
            begin
                v = {{14{code[1]}}, code[1:0]};
            end
            else
            begin
                v = {{12{code[3]}}, code};
            end
            return v << sh;
        end
    endfunction

    assign is_data = (kind == KIND_STREAM) && (pos_reg != 4'd0);
    assign d       = pos_reg - 4'd1;
    assign slot    = two_bit_mode ? {1'b0, d[0]} : d[1:0];
    assign base_new = two_bit_mode ? {slot[0], 2'b00} : {slot, 1'b0};
    assign endg_new = two_bit_mode ? (slot == 2'd1) : (slot == 2'd3);
    assign flen     = two_bit_mode ? 4'd4 : 4'd8;

    // Codebook storage.
    assign book_we = cmd.take && (kind == KIND_BOOK)
                     && ({2'b00, book_index} < 9'(BOOK_WORDS));
    assign waddr_w = {1'b0, book_index};
    assign row     = (cmd.term != 4'd0);
    assign col     = (cmd.term == 4'd0) ? cmd.j : 3'(cmd.j + 3'd1 - cmd.term[2:0]);
    assign raddr_w = {pred_reg, row, col};

    acb_ram #(.WIDTH(16), .DEPTH(BOOK_WORDS)) u_book (
        .clk   (clk),
        .we    (book_we),
        .waddr (waddr_w[ADDR_W-1:0]),
        .wdata (book_value),
        .raddr (raddr_w[ADDR_W-1:0]),
        .rdata (coef)
    );

    // Multiplier operand: older, newer, then earlier residuals of the group.
    always_comb
    begin
        case (cmd.term)
            4'd0:    operand = older_reg;
            4'd1:    operand = newer_reg;
            default: operand = res_reg[3'(cmd.term - 4'd2)];
        endcase
    end

    // Rounding toward minus infinity and saturation.
    assign q = acc_reg[ACC_W-1:FRAC_BITS];
    always_comb
    begin
        if (q < (ACC_W-FRAC_BITS)'(SAMPLE_MIN))
        begin
            q_sat = SAMPLE_MIN;
        end
        else if (q > (ACC_W-FRAC_BITS)'(SAMPLE_MAX))
        begin
            q_sat = SAMPLE_MAX;
        end
        else
        begin
            q_sat = q[15:0];
        end
    end

    // Frame, history and output control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            shift_reg     <= '0;
            pred_reg      <= '0;
            newer_reg     <= '0;
            older_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take && kind == KIND_HISTORY)
            begin
                newer_reg <= history_newer;
                older_reg <= history_older;
                pos_reg   <= '0;
            end
            else if (cmd.take && kind == KIND_STREAM)
            begin
                if (pos_reg == 4'd0)
                begin
                    shift_reg <= stream_byte[7:4];
                    pred_reg  <= pred_tab[stream_byte[3:0]];
                    pos_reg   <= 4'd1;
                end
                else if (pos_reg >= flen)
                begin
                    pos_reg <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + 4'd1;
                end
            end
            if (cmd.put && cmd.last && endg_reg)
            begin
                older_reg <= last_s_reg;
                newer_reg <= q_sat;
            end
            if (cmd.put)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Residuals, byte context and MAC.
    always_ff @(posedge clk)
    begin
        if (cmd.take && is_data)
        begin
            base_reg <= base_new;
            two_reg  <= two_bit_mode;
            endg_reg <= endg_new;
            if (two_bit_mode)
            begin
                res_reg[base_new]        <= make_res({2'b00, stream_byte[7:6]}, 1'b1, shift_reg);
                res_reg[base_new + 3'd1] <= make_res({2'b00, stream_byte[5:4]}, 1'b1, shift_reg);
                res_reg[base_new + 3'd2] <= make_res({2'b00, stream_byte[3:2]}, 1'b1, shift_reg);
                res_reg[base_new + 3'd3] <= make_res({2'b00, stream_byte[1:0]}, 1'b1, shift_reg);
            end
            else
            begin
                res_reg[base_new]        <= make_res(stream_byte[7:4], 1'b0, shift_reg);
                res_reg[base_new + 3'd1] <= make_res(stream_byte[3:0], 1'b0, shift_reg);
            end
        end
        if (cmd.init)
        begin
            acc_reg <= ACC_W'($signed(res_reg[cmd.j])) <<< FRAC_BITS;
        end
        else if (cmd.acc)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.mul)
        begin
            prod_reg <= $signed(coef) * operand;
        end
        if (cmd.put)
        begin
            last_s_reg     <= q_sat;
            out_sample_reg <= q_sat;
            out_last_reg   <= cmd.last;
        end
    end

    assign status.decode   = is_data;
    assign status.two_bit  = two_reg;
    assign status.base     = base_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_last   = out_last_reg;
endmodule

[rtl/acb_ctrl.sv]
// Controller: sequences samples and MAC terms for each data byte.
module acb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  acb_pkg::acb_status_t status,
    output acb_pkg::acb_cmd_t    cmd
);
    import acb_pkg::*;

    acb_state_t state_reg;
    acb_state_t state_next;
    logic [1:0] n_reg;
    logic [1:0] n_next;
    logic [3:0] term_reg;
    logic [3:0] term_next;
    logic [2:0] j;
    logic       last;

    assign j    = status.base + {1'b0, n_reg};
    assign last = status.two_bit ? (n_reg == 2'd3) : (n_reg == 2'd1);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        term_next  = term_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.decode)
                begin
                    state_next = ST_INIT;
                    n_next     = '0;
                end
            end
            ST_INIT:
            begin
                term_next  = '0;
                state_next = ST_RD;
            end
            ST_RD:  state_next = ST_MUL;
            ST_MUL: state_next = ST_ACC;
            ST_ACC:
            begin
                if (term_reg == {1'b0, j} + 4'd1)
                begin
                    state_next = ST_PUT;
                end
                else
                begin
                    term_next  = term_reg + 4'd1;
                    state_next = ST_RD;
                end
            end
            ST_PUT:
            begin
                if (status.out_free)
                begin
                    n_next     = n_reg + 2'd1;
                    state_next = last ? ST_IDLE : ST_INIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            term_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            term_reg  <= term_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    assign cmd.take = (state_reg == ST_IDLE) && in_valid;
    assign cmd.init = (state_reg == ST_INIT);
    assign cmd.mul  = (state_reg == ST_MUL);
    assign cmd.acc  = (state_reg == ST_ACC);
    assign cmd.put  = (state_reg == ST_PUT) && status.out_free;
    assign cmd.last = last;
    assign cmd.j    = j;
    assign cmd.term = term_reg;
endmodule

[rtl/adpcm_codebook_decoder.sv]
// Top level of the order-2 codebook ADPCM decoder.
//
//  channel | role  | payload
//  in_ch   | sink  | kind, stream_byte, book_index, book_value, history_newer/older
//  out_ch  | source| sample, last
//  cfg     | sink  | two_bit_mode (always ready)
//
// Codebook writes, history sets and header bytes are accepted straight from idle.
// A data byte decodes 2 or 4 samples; sample j of the group sums j+2 products, one
// term at a time on the single shared multiplier and the one codebook read port.
// While a byte is being decoded in_ch.ready is low; a full output register
// stalls the sequencer before it loads the next sample.
// Reset clears frame state and history; the codebook holds no reset value.
module adpcm_codebook_decoder #(
    parameter int PREDICTORS = acb_pkg::PREDICTORS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    acb_in_if.sink    in_ch,
    acb_out_if.source out_ch,
    acb_cfg_if.sink   cfg
);
    import acb_pkg::*;

    acb_cmd_t    cmd;
    acb_status_t status;
    logic        mode_reg;

    // Mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            mode_reg <= cfg.two_bit_mode;
        end
    end
    assign cfg.ready = 1'b1;

    acb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    acb_datapath #(.PREDICTORS(PREDICTORS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .two_bit_mode  (mode_reg),
        .kind          (in_ch.kind),
        .stream_byte   (in_ch.stream_byte),
        .book_index    (in_ch.book_index),
        .book_value    (in_ch.book_value),
        .history_newer (in_ch.history_newer),
        .history_older (in_ch.history_older),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .out_sample    (out_ch.sample),
        .out_last      (out_ch.last)
    );
endmodule

[rtl/acb_checker.sv]
// Port-level assertions of the decoder and their binding to the top level.
module acb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  in_kind,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_sample,
    input logic        out_last
);
    import acb_pkg::*;

    // A stalled sample holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_last))
        else $error("stalled output changed");

    // Items other than stream bytes never produce a sample.
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid && in_kind != KIND_STREAM |=> !out_valid)
        else $error("sample from a non-stream item");

    // More samples of a byte pending: input must be held off.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("input taken mid-byte");
endmodule

bind adpcm_codebook_decoder acb_checker u_acb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_kind    (in_ch.kind),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_sample (out_ch.sample),
    .out_last   (out_ch.last)
);
